>>> rtl/rbhu_pkg.sv
// Package with the shared types and constants of the readout block hit unpacker.
package rbhu_pkg;

   localparam int HIT_INDEX_BITS = 16;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0]  CLOCK_MAX = 6'd63;
   localparam logic [11:0] TAC_MAX   = 12'd4095;

   typedef enum logic [2:0] {
      PHASE_HEADER = 3'b001,
      PHASE_FIRST  = 3'b010,
      PHASE_SECOND = 3'b100
   } phase_type;

   typedef struct packed {
      logic [31:0] data_word;
      logic        end_of_buffer;
      logic        clear_hit_count;
   } req_type;

   typedef struct packed {
      logic [3:0]                module_id;
      logic [3:0]                cable_id;
      logic [4:0]                tac_address;
      logic [4:0]                tac_channel;
      logic [3:0]                calibration;
      logic [5:0]                clock_value;
      logic [11:0]               tac_value;
      logic [11:0]               qdc_value;
      logic [HIT_INDEX_BITS-1:0] hit_index;
   } rsp_type;

   // One command from the parser to the hit formatter.
   typedef struct packed {
      logic        clear;
      logic        hit;
      logic [3:0]  module_id;
      logic [3:0]  cable_id;
      logic [31:0] first_word;
      logic [11:0] qdc_value;
   } cmd_type;

   // Handshake between a queue and the stage on either side of it.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/rbhu_front.sv
// Word parser: tracks header and pair phases and issues hit and clear commands.
module rbhu_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  rbhu_pkg::req_type         req_data,
   input  rbhu_pkg::queue_status_type q_status,
   output logic                      q_push,
   output rbhu_pkg::cmd_type         q_cmd
);
   import rbhu_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [9:0]  words_left_ff, words_left_in;
   logic [3:0]  module_ff, module_in;
   logic [3:0]  cable_ff, cable_in;
   logic [31:0] held_ff, held_in;
   logic        accept;
   logic        hit;
   logic [9:0]  left_dec;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;
   assign left_dec = words_left_ff - 10'd1;

   always_comb begin
      phase_in      = phase_ff;
      words_left_in = words_left_ff;
      module_in     = module_ff;
      cable_in      = cable_ff;
      held_in       = held_ff;
      hit           = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PHASE_FIRST: begin
               held_in       = req_data.data_word;
               words_left_in = left_dec;
               phase_in      = PHASE_SECOND;
            end
            PHASE_SECOND: begin
               hit           = 1'b1;
               words_left_in = left_dec;
               phase_in      = (left_dec == 10'd0) ? PHASE_HEADER : PHASE_FIRST;
            end
            default: begin
               // An odd word count is rounded up to a whole number of pairs.
               module_in     = req_data.data_word[31:28];
               cable_in      = req_data.data_word[27:24];
               words_left_in = ({1'b0, req_data.data_word[8:0]} + 10'd1) & 10'h3fe;
               phase_in      = (words_left_in == 10'd0) ? PHASE_HEADER : PHASE_FIRST;
            end
         endcase
         if (req_data.end_of_buffer) begin
            phase_in      = PHASE_HEADER;
            words_left_in = 10'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_HEADER;
         words_left_ff <= 10'd0;
      end else begin
         phase_ff      <= phase_in;
         words_left_ff <= words_left_in;
      end
      module_ff <= module_in;
      cable_ff  <= cable_in;
      held_ff   <= held_in;
   end

   assign q_push           = accept && (hit || req_data.clear_hit_count);
   assign q_cmd.clear      = req_data.clear_hit_count;
   assign q_cmd.hit        = hit;
   assign q_cmd.module_id  = module_ff;
   assign q_cmd.cable_id   = cable_ff;
   assign q_cmd.first_word = held_ff;
   assign q_cmd.qdc_value  = req_data.data_word[11:0];

endmodule

>>> rtl/rbhu_queue.sv
// Short command queue that decouples the parser from the hit formatter.
module rbhu_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_push,
   input  rbhu_pkg::cmd_type          q_cmd,
   input  logic                       q_pop,
   output rbhu_pkg::queue_status_type q_status,
   output rbhu_pkg::cmd_type          q_head
);
   import rbhu_pkg::*;

   cmd_type                   mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   localparam logic [QUEUE_PTR_BITS-1:0] LAST_PTR = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_BITS-1:0] FULL_CNT = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);
   assign q_head         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         mem[wr_ptr_ff] <= q_cmd;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !q_pop) else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");
`endif

endmodule

>>> rtl/rbhu_back.sv
// Hit formatter: applies clears, numbers hits and holds the result register.
module rbhu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rbhu_pkg::queue_status_type q_status,
   input  rbhu_pkg::cmd_type          q_head,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output rbhu_pkg::rsp_type          rsp_data
);
   import rbhu_pkg::*;

   logic [HIT_INDEX_BITS-1:0] count_ff, count_in;
   logic [HIT_INDEX_BITS-1:0] base;
   logic                      out_valid_ff, out_valid_in;
   rsp_type                   out_ff, out_in;

   // A command is taken when the result register is free or drains this cycle.
   assign q_pop = !q_status.empty && (!out_valid_ff || rsp_pop);
   assign base  = q_head.clear ? '0 : count_ff;

   always_comb begin
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      if (q_pop) begin
         count_in = base;
         if (q_head.hit) begin
            if (base != '1) begin
               count_in = base + 1'b1;
            end
            out_valid_in       = 1'b1;
            out_in.module_id   = q_head.module_id;
            out_in.cable_id    = q_head.cable_id;
            out_in.tac_address = q_head.first_word[31:27];
            out_in.tac_channel = q_head.first_word[26:22];
            out_in.calibration = q_head.first_word[21:18];
            out_in.clock_value = CLOCK_MAX - q_head.first_word[17:12];
            out_in.tac_value   = TAC_MAX - q_head.first_word[11:0];
            out_in.qdc_value   = q_head.qdc_value;
            out_in.hit_index   = base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/readout_block_hit_unpacker.sv
// Top level of the readout block hit unpacker.
// The block takes one 32-bit readout word per cycle (header, then first and second words of
// each pair) and emits one hit record for every completed pair. A word is accepted in every
// cycle in which the two-entry command queue between the parser and the hit formatter has
// room. A hit record enters the queue with the word that completes its pair and moves on to
// the result register once that register is free. The result register lets new words
// in while a record waits to be popped, until the queue holds two commands.
// The hit index counts up from the last clear and stops at its maximum value.
module readout_block_hit_unpacker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  rbhu_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rbhu_pkg::rsp_type rsp_data
);
   import rbhu_pkg::*;

   logic             q_push;
   logic             q_pop;
   cmd_type          q_cmd;
   cmd_type          q_head;
   queue_status_type q_status;

   rbhu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_status (q_status),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   rbhu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop),
      .q_status (q_status),
      .q_head   (q_head)
   );

   rbhu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
